// ===== rtl/wes_pkg.sv =====
// Package for the weekly event scheduler: types, codes and sizes.
// Used by the channel interfaces, the cells, the result buffer, the top level
// and the checker. No dependencies.
package wes_pkg;

  // Number of event slots, one cell each.
  localparam int EVENT_SLOTS = 16;

  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [2:0] DAY_MAX    = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ON        = 3'd1,
    ACT_OFF       = 3'd2,
    ACT_TOGGLE    = 3'd3,
    ACT_PULSE_OFF = 3'd4,
    ACT_PULSE_ON  = 3'd5
  } act_t;

  typedef struct packed {
    logic [6:0] mask;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] act;
  } entry_t;

  // One scanned minute travelling down the chain with its running winner.
  typedef struct packed {
    logic       valid;
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] found;
  } token_t;

  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } wtime_t;

  // Results of one tick: one item, or two when the action is a pulse.
  typedef struct packed {
    logic       two;
    logic [2:0] act;
    logic       relay_a;
    logic       relay_b;
  } res_t;

  function automatic logic act_fires(input logic [2:0] a);
    return (a >= ACT_ON) && (a <= ACT_PULSE_ON);
  endfunction

  // Advances a weekly time by one minute.
  function automatic wtime_t next_minute(input wtime_t t);
    wtime_t n;
    n = t;
    if (t.minute == MINUTE_MAX) begin
      n.minute = '0;
      if (t.hour == HOUR_MAX) begin
        n.hour = '0;
        n.day  = (t.day == DAY_MAX) ? 3'd0 : t.day + 3'd1;
      end else begin
        n.hour = t.hour + 5'd1;
      end
    end else begin
      n.minute = t.minute + 6'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/wes_if.sv =====
// Valid/ready channel interfaces of the weekly event scheduler.
// Depends on wes_pkg.
interface wes_in_if import wes_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] entry_index;
  logic [6:0] entry_day_mask;
  logic [4:0] entry_hour;
  logic [5:0] entry_minute;
  logic [2:0] entry_action;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic [2:0] now_day;
  logic       time_valid;
  logic       relay_now;

  modport source (
    output valid, action, entry_index, entry_day_mask, entry_hour, entry_minute,
           entry_action, now_hour, now_minute, now_day, time_valid, relay_now,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_day_mask, entry_hour, entry_minute,
           entry_action, now_hour, now_minute, now_day, time_valid, relay_now,
    output ready
  );
endinterface

interface wes_out_if import wes_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] fired_action;
  logic       relay_on;
  logic       last_of_run;

  modport source (output valid, fired_action, relay_on, last_of_run, input ready);
  modport sink   (input valid, fired_action, relay_on, last_of_run, output ready);
endinterface

// ===== rtl/wes_cell.sv =====
// One cell of the scan chain: holds one event slot and checks the passing
// minute against it. Depends on wes_pkg.
module wes_cell import wes_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_entry,
  input  token_t tok_i,
  output token_t tok_o
);

  entry_t entry_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  always_comb begin
    hit = tok_i.valid && entry_r.mask[tok_i.day] && (entry_r.hour == tok_i.hour) &&
          (entry_r.minute == tok_i.minute) && act_fires(entry_r.act);
    tok_nxt = tok_i;
    // A later slot overrides the winner picked up so far.
    if (hit) begin
      tok_nxt.found = entry_r.act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/wes_resbuf.sv =====
// Result buffer: holds the one or two result items of a tick and hands them
// out on the result channel. Depends on wes_pkg and wes_out_if.
module wes_resbuf import wes_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  res_t            load_res,
  output logic            busy,
  wes_out_if.source       out_ch
);

  logic [1:0] cnt_r;
  res_t       res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_res.two ? 2'd2 : 2'd1;
    end else if (out_ch.valid && out_ch.ready) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign busy                = (cnt_r != 2'd0);
  assign out_ch.valid        = busy;
  assign out_ch.fired_action = res_r.act;
  assign out_ch.relay_on     = (cnt_r == 2'd2) ? res_r.relay_a : res_r.relay_b;
  assign out_ch.last_of_run  = (cnt_r == 2'd1);

endmodule

// ===== rtl/weekly_event_scheduler.sv =====
// Weekly event scheduler, top level. Depends on wes_pkg, wes_if, wes_cell
// and wes_resbuf.
//
// Input channel in_ch carries write, tick and stop items; result channel
// out_ch carries the fired action and the relay level, last_of_run marking
// the final item of a tick. Both use valid/ready.
// A write or stop item, and a tick that only records the time or is ignored,
// leaves the block idle. A tick that moves the time forward by M minutes
// injects one minute per cycle into a chain of EVENT_SLOTS cells, each
// holding one slot. Once the last minute has left the chain and the result
// buffer is free, the winning action, if any, is loaded into the buffer and
// the block returns to idle, ready for the next item.
// The block takes one item at a time: in_ch.ready is high only while no walk
// is under way. A finished result waits in the result buffer, and the next
// item is accepted meanwhile; a following walk holds at its end until the
// buffer has been emptied by the receiver.
// Synchronous reset clears the table to action none, the seen time to zero
// and forgets the time.
module weekly_event_scheduler import wes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  wes_in_if.sink   in_ch,
  wes_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  wtime_t     seen_r, seen_nxt;
  wtime_t     target_r;
  logic       known_r, known_nxt;
  logic       relay_r;
  logic [2:0] acc_r;
  wtime_t     step;
  wtime_t     now;
  token_t     tok [0:EVENT_SLOTS];
  entry_t     wr_entry;
  logic       accept;
  logic       tick_ok;
  logic       any_valid;
  logic       busy;
  logic       load;
  res_t       load_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign now.day    = in_ch.now_day;
  assign now.hour   = in_ch.now_hour;
  assign now.minute = in_ch.now_minute;
  assign tick_ok = in_ch.time_valid && (in_ch.now_hour <= HOUR_MAX) &&
                   (in_ch.now_minute <= MINUTE_MAX) && (in_ch.now_day <= DAY_MAX);

  assign wr_entry.mask   = in_ch.entry_day_mask;
  assign wr_entry.hour   = in_ch.entry_hour;
  assign wr_entry.minute = in_ch.entry_minute;
  assign wr_entry.act    = in_ch.entry_action;

  assign step = next_minute(seen_r);

  always_comb begin
    tok[0].valid  = (state_r == ST_WALK);
    tok[0].day    = step.day;
    tok[0].hour   = step.hour;
    tok[0].minute = step.minute;
    tok[0].found  = ACT_NONE;
  end

  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
    wes_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (accept && (in_ch.action == OP_WRITE) &&
                 (32'(in_ch.entry_index) == i)),
      .wr_entry (wr_entry),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  always_comb begin
    any_valid = 1'b0;
    for (int i = 1; i <= EVENT_SLOTS; i++) begin
      any_valid = any_valid | tok[i].valid;
    end
  end

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    known_nxt = known_r;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == OP_STOP) begin
            known_nxt = 1'b0;
          end else if ((in_ch.action == OP_TICK) && tick_ok) begin
            if (!known_r) begin
              seen_nxt  = now;
              known_nxt = 1'b1;
            end else if (now != seen_r) begin
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        seen_nxt = step;
        if (step == target_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait for the last minute to leave the chain and for a free buffer.
        if (!any_valid && !busy) begin
          load      = (acc_r != ACT_NONE);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      known_r <= 1'b0;
      acc_r   <= ACT_NONE;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      known_r <= known_nxt;
      if (accept) begin
        acc_r <= ACT_NONE;
      end else if (tok[EVENT_SLOTS].valid && (tok[EVENT_SLOTS].found != ACT_NONE)) begin
        acc_r <= tok[EVENT_SLOTS].found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r <= now;
      relay_r  <= in_ch.relay_now;
    end
  end

  always_comb begin
    load_res.act     = acc_r;
    load_res.two     = 1'b0;
    load_res.relay_a = 1'b0;
    load_res.relay_b = 1'b0;
    case (acc_r)
      ACT_ON:     load_res.relay_b = 1'b1;
      ACT_OFF:    load_res.relay_b = 1'b0;
      ACT_TOGGLE: load_res.relay_b = ~relay_r;
      ACT_PULSE_OFF: begin
        load_res.two     = 1'b1;
        load_res.relay_a = 1'b0;
        load_res.relay_b = 1'b1;
      end
      ACT_PULSE_ON: begin
        load_res.two     = 1'b1;
        load_res.relay_a = 1'b1;
        load_res.relay_b = 1'b0;
      end
      default: load_res.relay_b = 1'b0;
    endcase
  end

  wes_resbuf u_resbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .load_res (load_res),
    .busy     (busy),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/wes_sva.sv =====
// Port-level checker for the weekly event scheduler, bound to the top level.
// Depends on wes_pkg.
module wes_sva import wes_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] fired_action,
  input logic       relay_on,
  input logic       last_of_run
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fired_action) &&
    $stable(relay_on) && $stable(last_of_run))
    else $error("result item changed while stalled");

  // The first item of a pulse is followed at once by the closing item.
  a_pulse_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=>
      out_valid && last_of_run && (fired_action == $past(fired_action)) &&
      (relay_on != $past(relay_on)))
    else $error("pulse not closed by its second item");

  // Only a real action code is ever reported.
  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fired_action == ACT_ON) || (fired_action == ACT_OFF) ||
                  (fired_action == ACT_TOGGLE) || (fired_action == ACT_PULSE_OFF) ||
                  (fired_action == ACT_PULSE_ON))
    else $error("invalid fired action");

  // On and off items drive a fixed level and end the run.
  a_on_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((fired_action == ACT_ON) || (fired_action == ACT_OFF)) |->
      last_of_run && (relay_on == (fired_action == ACT_ON)))
    else $error("on/off item with wrong level or run marker");

endmodule

bind weekly_event_scheduler wes_sva u_wes_sva (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .fired_action (out_ch.fired_action),
  .relay_on     (out_ch.relay_on),
  .last_of_run  (out_ch.last_of_run)
);

// ===== verif/tb.sv =====
// Testbench for weekly_event_scheduler: directed and random write, tick and stop items
// are checked against a built-in predictor of the event table and the weekly clock.
// Depends on wes_pkg, wes_if and the RTL of the block.
`timescale 1ns / 100ps

module tb import wes_pkg::*;;

  localparam int          CLK_HALF       = 10;
  localparam int          TIMEOUT_CYCLES = 600_000;
  localparam int          SETTLE_LIMIT   = 40_000;
  localparam int          TAIL_CYCLES    = 40;
  localparam int unsigned MIN_PER_HOUR   = 60;
  localparam int unsigned MIN_PER_DAY    = 1440;
  localparam int unsigned WEEK_MINUTES   = 10080;
  localparam int          RANDOM_ITEMS   = 540;

  // Codes the package leaves unnamed: a fourth operation and two unknown actions.
  localparam logic [1:0] OP_NOP    = 2'd3;
  localparam logic [2:0] ACT_BAD6  = 3'd6;
  localparam logic [2:0] ACT_BAD7  = 3'd7;

  typedef struct {
    logic [1:0] op;
    logic [3:0] idx;
    logic [6:0] mask;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] act;
    logic [4:0] now_h;
    logic [5:0] now_m;
    logic [2:0] now_d;
    logic       tv;
    logic       relay;
  } sched_cmd_t;

  typedef struct {
    logic [2:0] act;
    logic       relay;
    logic       last;
  } fire_t;

  logic clk = 1'b0;
  logic rst_n;

  wes_in_if  in_ch ();
  wes_out_if out_ch ();

  weekly_event_scheduler i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state.
  entry_t     slot_tab [EVENT_SLOTS];
  wtime_t     clock_at;
  bit         clock_known;
  fire_t      fires_due [$];

  // Run control and statistics.
  bit          no_gaps;
  int          hold_left;
  int          big_left;
  int unsigned n_items, n_walks, n_results, n_fail;
  int unsigned fired_count [8];

  always #CLK_HALF clk = ~clk;

  function automatic wtime_t shift_time(input wtime_t t, input int unsigned k);
    int unsigned m;
    wtime_t      r;
    m = (t.day * MIN_PER_DAY + t.hour * MIN_PER_HOUR + t.minute + k) % WEEK_MINUTES;
    r.day    = 3'(m / MIN_PER_DAY);
    r.hour   = 5'((m / MIN_PER_HOUR) % 24);
    r.minute = 6'(m % MIN_PER_HOUR);
    return r;
  endfunction

  // Updates the table and the clock for one accepted item and queues the relay results.
  task automatic predict_schedule(input sched_cmd_t c);
    wtime_t     target;
    logic [2:0] won;
    case (c.op)
      OP_WRITE: begin
        if (c.idx < EVENT_SLOTS) begin
          slot_tab[c.idx].mask   = c.mask;
          slot_tab[c.idx].hour   = c.hour;
          slot_tab[c.idx].minute = c.minute;
          slot_tab[c.idx].act    = c.act;
        end
      end
      OP_STOP: clock_known = 1'b0;
      OP_TICK: begin
        if (c.tv && c.now_h <= HOUR_MAX && c.now_m <= MINUTE_MAX && c.now_d <= DAY_MAX) begin
          target.day    = c.now_d;
          target.hour   = c.now_h;
          target.minute = c.now_m;
          if (!clock_known) begin
            clock_at    = target;
            clock_known = 1'b1;
          end else if (target != clock_at) begin
            won = ACT_NONE;
            // Every minute of the walk is scanned; later slots and later minutes win.
            while (clock_at != target) begin
              clock_at = shift_time(clock_at, 1);
              for (int i = 0; i < EVENT_SLOTS; i++) begin
                if (slot_tab[i].mask[clock_at.day] && slot_tab[i].hour == clock_at.hour &&
                    slot_tab[i].minute == clock_at.minute &&
                    slot_tab[i].act >= ACT_ON && slot_tab[i].act <= ACT_PULSE_ON)
                  won = slot_tab[i].act;
              end
            end
            n_walks++;
            case (won)
              ACT_ON:        fires_due.push_back('{ACT_ON, 1'b1, 1'b1});
              ACT_OFF:       fires_due.push_back('{ACT_OFF, 1'b0, 1'b1});
              ACT_TOGGLE:    fires_due.push_back('{ACT_TOGGLE, ~c.relay, 1'b1});
              ACT_PULSE_OFF: begin
                fires_due.push_back('{ACT_PULSE_OFF, 1'b0, 1'b0});
                fires_due.push_back('{ACT_PULSE_OFF, 1'b1, 1'b1});
              end
              ACT_PULSE_ON: begin
                fires_due.push_back('{ACT_PULSE_ON, 1'b1, 1'b0});
                fires_due.push_back('{ACT_PULSE_ON, 1'b0, 1'b1});
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic sched_cmd_t random_fill(input logic [1:0] op);
    sched_cmd_t c;
    c.op     = op;
    c.idx    = 4'($urandom);
    c.mask   = 7'($urandom);
    c.hour   = 5'($urandom);
    c.minute = 6'($urandom);
    c.act    = 3'($urandom);
    c.now_h  = 5'($urandom);
    c.now_m  = 6'($urandom);
    c.now_d  = 3'($urandom);
    c.tv     = 1'($urandom);
    c.relay  = 1'($urandom);
    return c;
  endfunction

  function automatic sched_cmd_t mk_write(input logic [3:0] idx, input logic [6:0] mask,
                                          input logic [4:0] hour, input logic [5:0] minute,
                                          input logic [2:0] act);
    sched_cmd_t c;
    c        = random_fill(OP_WRITE);
    c.idx    = idx;
    c.mask   = mask;
    c.hour   = hour;
    c.minute = minute;
    c.act    = act;
    return c;
  endfunction

  function automatic sched_cmd_t mk_tick(input logic [2:0] day, input logic [4:0] hour,
                                         input logic [5:0] minute, input logic tv,
                                         input logic relay);
    sched_cmd_t c;
    c       = random_fill(OP_TICK);
    c.now_d = day;
    c.now_h = hour;
    c.now_m = minute;
    c.tv    = tv;
    c.relay = relay;
    return c;
  endfunction

  function automatic sched_cmd_t mk_tick_after(input int unsigned k);
    wtime_t t;
    t = shift_time(clock_at, k);
    return mk_tick(t.day, t.hour, t.minute, 1'b1, 1'($urandom));
  endfunction

  task automatic send_item(input sched_cmd_t c);
    if (!no_gaps && $urandom_range(99) < 28) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.action         = c.op;
    in_ch.entry_index    = c.idx;
    in_ch.entry_day_mask = c.mask;
    in_ch.entry_hour     = c.hour;
    in_ch.entry_minute   = c.minute;
    in_ch.entry_action   = c.act;
    in_ch.now_hour       = c.now_h;
    in_ch.now_minute     = c.now_m;
    in_ch.now_day        = c.now_d;
    in_ch.time_valid     = c.tv;
    in_ch.relay_now      = c.relay;
    do @(posedge clk); while (!in_ch.ready);
    predict_schedule(c);
    n_items++;
    @(negedge clk);
  endtask

  // Lowers valid and waits until every expected result is out and no walk is running.
  task automatic settle();
    int unsigned waited;
    in_ch.valid = 1'b0;
    waited = 0;
    while ((fires_due.size() != 0 || !in_ch.ready) && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(mk_tick(3'd1, 5'd3, 6'd4, 1'b0, 1'b0));      // clock not set
    send_item(random_fill(OP_NOP));
    send_item(random_fill(OP_STOP));
    send_item(mk_tick(3'd7, 5'd31, 6'd63, 1'b1, 1'b1));    // out of range
    send_item(mk_tick(3'd6, 5'd23, 6'd59, 1'b1, 1'b0));    // first valid tick only records
    send_item(mk_write(4'd0, 7'h01, 5'd0, 6'd0, ACT_ON));
    send_item(mk_write(4'd15, 7'h7f, 5'd0, 6'd1, ACT_TOGGLE));
    send_item(mk_write(4'd1, 7'h7f, 5'd31, 6'd63, ACT_PULSE_ON));
    send_item(mk_write(4'd2, 7'h7f, 5'd0, 6'd3, ACT_BAD7));
    send_item(mk_write(4'd8, 7'h7f, 5'd0, 6'd3, ACT_BAD6));
    // Saturday 23:59 to Sunday 0:00 wraps minute, hour and day at once.
    send_item(mk_tick(3'd0, 5'd0, 6'd0, 1'b1, 1'b0));
    send_item(mk_tick(3'd0, 5'd0, 6'd0, 1'b1, 1'b0));       // same time again
    send_item(mk_tick(3'd0, 5'd0, 6'd1, 1'b1, 1'b1));
    send_item(mk_write(4'd15, 7'h01, 5'd0, 6'd2, ACT_TOGGLE));
    send_item(mk_tick(3'd0, 5'd0, 6'd2, 1'b1, 1'b0));
    send_item(mk_write(4'd4, 7'h7f, 5'd0, 6'd3, ACT_PULSE_OFF));
    send_item(mk_write(4'd3, 7'h7f, 5'd0, 6'd4, ACT_OFF));
    send_item(mk_tick(3'd0, 5'd0, 6'd4, 1'b1, 1'b1));       // two matches, later one wins
    send_item(mk_write(4'd5, 7'h7f, 5'd0, 6'd5, ACT_PULSE_ON));
    send_item(mk_write(4'd6, 7'h7f, 5'd0, 6'd5, ACT_PULSE_OFF));
    send_item(mk_tick(3'd0, 5'd0, 6'd5, 1'b1, 1'b0));
    send_item(mk_write(4'd6, 7'h7f, 5'd0, 6'd7, ACT_PULSE_ON));
    send_item(mk_tick(3'd0, 5'd0, 6'd7, 1'b1, 1'b0));
    send_item(mk_tick(3'd0, 5'd0, 6'd30, 1'b1, 1'b0));      // walk without a match
    send_item(random_fill(OP_STOP));
    send_item(mk_tick(3'd1, 5'd5, 6'd0, 1'b1, 1'b0));
    send_item(mk_tick(3'd1, 5'd5, 6'd60, 1'b1, 1'b0));
    settle();
  endtask

  // The receiver holds off while one-minute ticks keep firing pulses.
  task automatic test_stalled_receiver();
    wtime_t t;
    no_gaps = 1'b1;
    if (!clock_known)
      send_item(mk_tick(3'($urandom_range(6)), 5'($urandom_range(23)),
                        6'($urandom_range(59)), 1'b1, 1'b0));
    for (int i = 0; i < EVENT_SLOTS; i++) begin
      t = shift_time(clock_at, i + 1);
      send_item(mk_write(4'(i), 7'h7f, t.hour, t.minute,
                         (i % 2) ? ACT_PULSE_ON : ACT_PULSE_OFF));
    end
    hold_left = 400;
    for (int i = 0; i < EVENT_SLOTS; i++)
      send_item(mk_tick_after(1));
    no_gaps = 1'b0;
    settle();
  endtask

  task automatic test_long_walks();
    wtime_t t;
    t = shift_time(clock_at, 20);
    send_item(mk_write(4'd9, 7'h7f, t.hour, t.minute, ACT_TOGGLE));
    send_item(mk_tick_after(WEEK_MINUTES - 1));
    send_item(mk_tick_after(4321));
    settle();
  endtask

  task automatic test_random_traffic();
    sched_cmd_t  c;
    wtime_t      t;
    int unsigned pick, r, step;
    big_left = 3;
    no_gaps  = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120)
        no_gaps = 1'b0;
      pick = $urandom_range(99);
      if (pick < 25) begin
        c = random_fill(OP_WRITE);
        t = shift_time(clock_at, $urandom_range(1, 24));
        if ($urandom_range(9) != 0) begin
          c.hour   = t.hour;
          c.minute = t.minute;
          c.mask   = ($urandom_range(1) == 1) ? 7'h7f : (c.mask | (7'h01 << t.day));
        end
        if ($urandom_range(9) < 8)
          c.act = 3'($urandom_range(ACT_ON, ACT_PULSE_ON));
      end else if (pick < 90) begin
        c    = random_fill(OP_TICK);
        c.tv = ($urandom_range(19) != 0);
        r    = $urandom_range(99);
        if (r < 4) begin
          case ($urandom_range(2))
            0:       c.now_h = 5'($urandom_range(24, 31));
            1:       c.now_m = 6'($urandom_range(60, 63));
            default: c.now_d = 3'd7;
          endcase
        end else begin
          if (r < 10)
            step = 0;
          else if (r < 85)
            step = $urandom_range(1, 12);
          else if (r == 99 && big_left > 0) begin
            step = $urandom_range(1000, WEEK_MINUTES - 1);
            big_left--;
          end else
            step = $urandom_range(13, 400);
          if (clock_known)
            t = shift_time(clock_at, step);
          else begin
            t.day    = 3'($urandom_range(6));
            t.hour   = 5'($urandom_range(23));
            t.minute = 6'($urandom_range(59));
          end
          c.now_d = t.day;
          c.now_h = t.hour;
          c.now_m = t.minute;
        end
      end else if (pick < 95)
        c = random_fill(OP_STOP);
      else if (pick < 98)
        c = random_fill(OP_NOP);
      else
        c = random_fill(OP_WRITE);
      send_item(c);
    end
    settle();
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    fire_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      fired_count[out_ch.fired_action]++;
      if (fires_due.size() == 0) begin
        $error("unexpected result: fired_action %0d relay_on %0d last_of_run %0d",
               out_ch.fired_action, out_ch.relay_on, out_ch.last_of_run);
        n_fail++;
      end else begin
        want = fires_due.pop_front();
        if (out_ch.fired_action !== want.act) begin
          $error("fired_action: expected %0d, got %0d", want.act, out_ch.fired_action);
          n_fail++;
        end
        if (out_ch.relay_on !== want.relay) begin
          $error("relay_on: expected %0d, got %0d", want.relay, out_ch.relay_on);
          n_fail++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_ch.last_of_run);
          n_fail++;
        end
      end
    end
  end

  // Receiver: random stalls, none during a quiet stretch, and a counted hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (no_gaps) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= 28);
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = OP_WRITE;
    in_ch.entry_index    = '0;
    in_ch.entry_day_mask = '0;
    in_ch.entry_hour     = '0;
    in_ch.entry_minute   = '0;
    in_ch.entry_action   = ACT_NONE;
    in_ch.now_hour       = '0;
    in_ch.now_minute     = '0;
    in_ch.now_day        = '0;
    in_ch.time_valid     = 1'b0;
    in_ch.relay_now      = 1'b0;
    out_ch.ready         = 1'b0;
    no_gaps              = 1'b1;
    hold_left            = 0;
    clock_known          = 1'b0;
    clock_at             = '0;
    for (int i = 0; i < EVENT_SLOTS; i++)
      slot_tab[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_stalled_receiver();
    test_long_walks();
    test_random_traffic();

    if (fires_due.size() != 0) begin
      $error("%0d expected results never arrived", fires_due.size());
      n_fail++;
    end
    $display("Sent %0d items, %0d of them ticks that walked the clock; checked %0d results.",
             n_items, n_walks, n_results);
    $display("Fired on %0d, off %0d, toggle %0d, pulse off %0d, pulse on %0d; %0d failures.",
             fired_count[ACT_ON], fired_count[ACT_OFF], fired_count[ACT_TOGGLE],
             fired_count[ACT_PULSE_OFF], fired_count[ACT_PULSE_ON], n_fail);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Timeout with %0d results still expected.", fires_due.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== weekly_event_scheduler.f =====
rtl/wes_pkg.sv
rtl/wes_if.sv
rtl/wes_cell.sv
rtl/wes_resbuf.sv
rtl/weekly_event_scheduler.sv
rtl/wes_sva.sv
verif/tb.sv
